[design/spq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DATA_W = 32;
	localparam int PRIO_W = 16;

	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_READOUT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_READ     = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic signed [PRIO_W-1:0] prio;
	} entry_t;

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_INS_CMP  = 5'b00010,
		S_INS_LAST = 5'b00100,
		S_RD_WAIT  = 5'b01000,
		S_RESP     = 5'b10000
	} state_t;

endpackage
`default_nettype wire

[design/spq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[design/sorted_priority_queue_insert_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_insert_core
// Bounded queue of (data, priority) entries kept in ascending priority order.
// ----------------------------------------------------------------------------
// Entries live in one RAM with a registered read. An insert walks down from
// the top entry, moving each entry with a greater priority up by one slot,
// one entry per cycle, and writes the new entry into the gap; equal
// priorities keep arrival order. A full queue drops the word. A readout
// streams every entry, one per cycle while the output is taken. The single
// RAM port pair sets this pace. One output register holds the pending
// result word.
module sorted_priority_queue_insert_core #(
	parameter int CAPACITY = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               op,
	input  wire logic signed [spq_pkg::DATA_W-1:0]  item_data,
	input  wire logic signed [spq_pkg::PRIO_W-1:0]  item_priority,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [spq_pkg::DATA_W-1:0]       out_data,
	output logic signed [spq_pkg::PRIO_W-1:0]       out_priority,
	output logic                                    last,
	output logic [1:0]                              status
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = $bits(spq_pkg::entry_t);

	spq_pkg::state_t  state_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    idx_q;
	logic signed [spq_pkg::DATA_W-1:0] new_data_q;
	logic signed [spq_pkg::PRIO_W-1:0] new_prio_q;
	spq_pkg::status_t status_q;

	logic             out_valid_q;
	logic signed [spq_pkg::DATA_W-1:0] out_data_q;
	logic signed [spq_pkg::PRIO_W-1:0] out_prio_q;
	logic             out_last_q;
	spq_pkg::status_t out_status_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [EW-1:0]    ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [EW-1:0]    ram_rdata;
	spq_pkg::entry_t  rd_entry;
	spq_pkg::entry_t  new_entry;

	logic             slot_free;
	logic             shift;
	logic [CW-1:0]    cnt_m1;
	logic             last_ent;
	logic             push_ent;
	logic             push_resp;
	logic             in_fire;

	spq_ram #(
		.WIDTH(EW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_ready  = (state_q == spq_pkg::S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign rd_entry  = spq_pkg::entry_t'(ram_rdata);
	assign new_entry = '{data: new_data_q, prio: new_prio_q};
	assign shift     = rd_entry.prio > new_prio_q;
	assign cnt_m1    = count_q - CW'(1);
	assign last_ent  = (CW'(idx_q) == cnt_m1);
	assign push_ent  = (state_q == spq_pkg::S_RD_WAIT) && slot_free;
	assign push_resp = (state_q == spq_pkg::S_RESP) && slot_free;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = new_entry;
		ram_raddr = idx_q;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				ram_raddr = (op == spq_pkg::OP_INSERT) ? cnt_m1[AW-1:0] : '0;
			end
			spq_pkg::S_INS_CMP: begin
				ram_we = 1'b1;
				if (shift) begin
					ram_wdata = ram_rdata;
					ram_raddr = idx_q - AW'(2);
				end
			end
			spq_pkg::S_INS_LAST: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
			end
			spq_pkg::S_RD_WAIT: begin
				ram_raddr = slot_free ? idx_q + AW'(1) : idx_q;
			end
			spq_pkg::S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				spq_pkg::S_IDLE: begin
					if (in_fire) begin
						if (op == spq_pkg::OP_INSERT) begin
							if (count_q == CW'(CAPACITY)) begin
								state_q <= spq_pkg::S_RESP;
							end else if (count_q == '0) begin
								state_q <= spq_pkg::S_INS_LAST;
							end else begin
								idx_q   <= count_q[AW-1:0];
								state_q <= spq_pkg::S_INS_CMP;
							end
						end else begin
							idx_q <= '0;
							if (count_q == '0) begin
								state_q <= spq_pkg::S_RESP;
							end else begin
								state_q <= spq_pkg::S_RD_WAIT;
							end
						end
					end
				end
				spq_pkg::S_INS_CMP: begin
					if (shift) begin
						if (idx_q == AW'(1)) begin
							state_q <= spq_pkg::S_INS_LAST;
						end else begin
							idx_q <= idx_q - AW'(1);
						end
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= spq_pkg::S_RESP;
					end
				end
				spq_pkg::S_INS_LAST: begin
					count_q <= count_q + CW'(1);
					state_q <= spq_pkg::S_RESP;
				end
				spq_pkg::S_RD_WAIT: begin
					if (slot_free) begin
						if (last_ent) begin
							state_q <= spq_pkg::S_IDLE;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
				end
				spq_pkg::S_RESP: begin
					if (slot_free) begin
						state_q <= spq_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= spq_pkg::S_IDLE;
				end
			endcase
		end
	end

	// latch the incoming word and its answer code, marked inserted once the insert completes
	always_ff @(posedge clk) begin
		if (in_fire) begin
			new_data_q <= item_data;
			new_prio_q <= item_priority;
			if (op == spq_pkg::OP_INSERT) begin
				status_q <= spq_pkg::ST_FULL;
			end else begin
				status_q <= spq_pkg::ST_EMPTY;
			end
		end else if ((state_q == spq_pkg::S_INS_LAST)
				|| ((state_q == spq_pkg::S_INS_CMP) && !shift)) begin
			status_q <= spq_pkg::ST_INSERTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_ent || push_resp) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ent) begin
			out_data_q   <= rd_entry.data;
			out_prio_q   <= rd_entry.prio;
			out_last_q   <= last_ent;
			out_status_q <= spq_pkg::ST_READ;
		end else if (push_resp) begin
			out_data_q   <= '0;
			out_prio_q   <= '0;
			out_last_q   <= 1'b1;
			out_status_q <= status_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;
	assign out_priority = out_prio_q;
	assign last         = out_last_q;
	assign status       = out_status_q;

endmodule
`default_nettype wire

[design/spq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic signed [spq_pkg::DATA_W-1:0] out_data,
	input wire logic signed [spq_pkg::PRIO_W-1:0] out_priority,
	input wire logic                              last,
	input wire logic [1:0]                        status
);

	// a held result word keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)
			&& $stable(out_priority) && $stable(last) && $stable(status))
		else $error("result word changed while stalled");

	// only readout entries may continue a burst
	a_nonlast_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == spq_pkg::ST_READ)
		else $error("non-final word without entry status");

	// status-only words are single, with zero payload
	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == spq_pkg::ST_INSERTED || status == spq_pkg::ST_FULL
			|| status == spq_pkg::ST_EMPTY)
		|-> last && out_data == '0 && out_priority == '0)
		else $error("status word malformed");

	// the block is busy right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");

endmodule

bind sorted_priority_queue_insert_core spq_checker u_spq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_data    (out_data),
	.out_priority(out_priority),
	.last        (last),
	.status      (status)
);
`default_nettype wire
